// ===== design/rrfi_pkg.sv =====
// Package for the register read fault injector.
// Sizes, request/status/mode codes and packed entry type; no dependencies.
`default_nettype none
package rrfi_pkg;
    localparam int DEVICES = 4;
    localparam int SLOTS = 16;
    localparam int DEV_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int MEM_DEPTH = DEVICES * SLOTS;
    localparam int MEM_AW = $clog2(MEM_DEPTH);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_APPLY  = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_FLIP  = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    typedef struct packed {
        logic [31:0] addr;
        logic [4:0]  bitn;
        logic [1:0]  mode;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

// ===== design/rrfi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module rrfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/register_read_fault_injector_core.sv =====
// Top level of the register read fault injector: sequencer over entry RAM.
// Uses rrfi_pkg and rrfi_ram.
//
//  channel | signals                                          | dir
//  req     | req_valid/req_ready, req_type..byte_count         | in
//  rsp     | rsp_valid/rsp_ready, result_data,status,entries_now| out
//  cfg     | cfg_we, cfg_data (device_present)                | in
//
// One item at a time; at most one RAM read per cycle through the single read port.
// Apply and remove read every entry of the device; an insert scans up to its
// position, shifts the later entries up one slot, then writes the new entry.
// Absent device, full table and unused type answer the cycle after accept.
// Reset clears counts and present bits; entry RAM is not cleared.
// A waiting result holds off input; the next item is taken after it is sent.
`default_nettype none
module register_read_fault_injector_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [1:0]  device,
    input  wire logic [31:0] address,
    input  wire logic [4:0]  bit_number,
    input  wire logic [1:0]  fault_mode,
    input  wire logic [31:0] read_data,
    input  wire logic [2:0]  byte_count,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [31:0]      result_data,
    output logic [1:0]       status,
    output logic [4:0]       entries_now,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_data
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_PUT    = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    localparam int CW = rrfi_pkg::CNT_W;
    localparam int DW = rrfi_pkg::DEV_W;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  present_reg;
    logic [CW-1:0] count_reg [rrfi_pkg::DEVICES];

    logic [1:0]  type_reg;
    logic [DW-1:0] dev_reg;
    logic [31:0] addr_reg;
    logic [4:0]  bit_reg;
    logic [1:0]  mode_reg;
    logic [31:0] data_reg, data_next;
    logic [2:0]  bc_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] r_reg, r_next;   // read index issued
    logic [CW-1:0] w_reg, w_next;   // write index (remove) / shift index (insert)
    logic        rv_reg, rv_next;   // RAM output valid for index rd_idx_reg
    logic [CW-1:0] rd_idx_reg;
    logic [31:0] res_reg;
    logic [1:0]  st_reg;
    logic [4:0]  ent_reg;
    logic        out_v_reg;

    logic        ram_we;
    logic [rrfi_pkg::MEM_AW-1:0] ram_waddr, ram_raddr;
    rrfi_pkg::entry_t ram_wdata, ram_rdata;

    rrfi_ram #(
        .WIDTH(rrfi_pkg::ENTRY_W),
        .DEPTH(rrfi_pkg::MEM_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    function automatic logic [rrfi_pkg::MEM_AW-1:0] mem_addr(
        input logic [DW-1:0] d, input logic [CW-1:0] i);
        logic [rrfi_pkg::MEM_AW+CW:0] t;
        begin
            t = (rrfi_pkg::MEM_AW+CW+1)'(d) * (rrfi_pkg::MEM_AW+CW+1)'(rrfi_pkg::SLOTS)
                + (rrfi_pkg::MEM_AW+CW+1)'(i);
            mem_addr = t[rrfi_pkg::MEM_AW-1:0];
        end
    endfunction

    assign req_ready = (state_reg == S_IDLE) && !out_v_reg;
    assign rsp_valid = out_v_reg;
    assign result_data = res_reg;
    assign status = st_reg;
    assign entries_now = ent_reg;

    logic accept;
    assign accept = req_valid && req_ready;

    logic        dev_ok;
    logic        ins_full;
    logic        answer_now;
    logic [DW-1:0] dev_in;
    assign dev_in = DW'(device);
    assign dev_ok = (32'(device) < rrfi_pkg::DEVICES) && present_reg[device];
    assign ins_full = (req_type == rrfi_pkg::REQ_INSERT)
                      && (count_reg[dev_in] >= CW'(rrfi_pkg::SLOTS));
    assign answer_now = !dev_ok || ins_full || (req_type == rrfi_pkg::REQ_RSVD);

    // apply of one entry
    logic [31:0] fbyte, off, mask;
    logic [2:0]  bc_eff;
    logic [4:0]  shamt;
    logic [31:0] applied;
    always_comb
    begin
        bc_eff = (bc_reg > 3'd4) ? 3'd4 : bc_reg;
        fbyte = ram_rdata.addr + 32'(ram_rdata.bitn[4:3]);
        off = fbyte - addr_reg;
        shamt = {off[1:0], ram_rdata.bitn[2:0]};
        mask = 32'd1 << shamt;
        applied = data_reg;
        if (off < 32'(bc_eff))
        begin
            case (ram_rdata.mode)
                rrfi_pkg::MODE_CLEAR: applied = data_reg & ~mask;
                rrfi_pkg::MODE_SET:   applied = data_reg | mask;
                rrfi_pkg::MODE_FLIP:  applied = data_reg ^ mask;
                default:              applied = data_reg;
            endcase
        end
    end

    logic hit;
    assign hit = (ram_rdata.addr == addr_reg) && (ram_rdata.bitn == bit_reg)
                 && (ram_rdata.mode == mode_reg);

    rrfi_pkg::entry_t new_entry;
    always_comb
    begin
        new_entry.addr = addr_reg;
        new_entry.bitn = bit_reg;
        new_entry.mode = (mode_reg == rrfi_pkg::MODE_RSVD) ? rrfi_pkg::MODE_CLEAR : mode_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        r_next = r_reg;
        w_next = w_reg;
        rv_next = 1'b0;
        data_next = data_reg;
        ram_we = 1'b0;
        ram_waddr = mem_addr(dev_reg, w_reg);
        ram_wdata = ram_rdata;
        ram_raddr = mem_addr(dev_reg, r_reg);
        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = mem_addr(dev_in, '0);
                if (accept && !answer_now)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue reads for apply, remove, insert position search
                if (r_reg < n_reg)
                begin
                    rv_next = 1'b1;
                    r_next = r_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    case (type_reg)
                        rrfi_pkg::REQ_APPLY: data_next = applied;
                        rrfi_pkg::REQ_REMOVE:
                        begin
                            if (!hit)
                            begin
                                ram_we = 1'b1;
                                w_next = w_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            // insert: stop at first entry with addr >= new
                            if (!(addr_reg > ram_rdata.addr))
                            begin
                                rv_next = 1'b0;
                                r_next = rd_idx_reg;
                                w_next = n_reg;
                                state_next = S_SHIFT;
                            end
                        end
                    endcase
                end
                if (state_next == S_SCAN && !rv_next && !(rv_reg && r_reg < n_reg))
                begin
                    if (!(r_reg < n_reg))
                    begin
                        if (type_reg == rrfi_pkg::REQ_INSERT)
                        begin
                            r_next = n_reg;
                            w_next = n_reg;
                            state_next = S_PUT;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                // r_reg holds pos; w_reg walks down from n to pos+1
                if (rv_reg)
                begin
                    ram_we = 1'b1;
                    w_next = w_reg - 1'b1;
                    if (w_reg - 1'b1 == r_reg)
                    begin
                        state_next = S_PUT;
                    end
                end
                else if (w_reg == r_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ram_raddr = mem_addr(dev_reg, w_reg - 1'b1);
                    rv_next = 1'b1;
                end
            end
            S_PUT:
            begin
                ram_we = 1'b1;
                ram_waddr = mem_addr(dev_reg, r_reg);
                ram_wdata = new_entry;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            present_reg <= '0;
            out_v_reg <= 1'b0;
            rv_reg <= 1'b0;
            for (int i = 0; i < rrfi_pkg::DEVICES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            rv_reg <= rv_next;
            if (cfg_we)
            begin
                present_reg <= cfg_data;
            end
            if (out_v_reg && rsp_ready)
            begin
                out_v_reg <= 1'b0;
            end
            if (accept && answer_now)
            begin
                out_v_reg <= 1'b1;
            end
            if (state_reg == S_RESP)
            begin
                out_v_reg <= 1'b1;
                if (type_reg == rrfi_pkg::REQ_INSERT)
                begin
                    count_reg[dev_reg] <= n_reg + 1'b1;
                end
                else if (type_reg == rrfi_pkg::REQ_REMOVE)
                begin
                    count_reg[dev_reg] <= w_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rv_next)
        begin
            rd_idx_reg <= (state_reg == S_SHIFT) ? w_reg - 1'b1 : r_reg;
        end
        if (accept)
        begin
            type_reg <= req_type;
            dev_reg <= dev_in;
            addr_reg <= address;
            bit_reg <= bit_number;
            mode_reg <= fault_mode;
            data_reg <= read_data;
            bc_reg <= byte_count;
            n_reg <= count_reg[dev_in];
            r_reg <= '0;
            w_reg <= '0;
            res_reg <= '0;
            st_reg <= (!dev_ok) ? rrfi_pkg::ST_ABSENT
                    : ins_full ? rrfi_pkg::ST_FULL
                    : rrfi_pkg::ST_OK;
            ent_reg <= (32'(device) < rrfi_pkg::DEVICES) ? 5'(count_reg[dev_in]) : 5'd0;
        end
        else
        begin
            r_reg <= r_next;
            w_reg <= w_next;
            data_reg <= data_next;
        end
        if (state_reg == S_RESP)
        begin
            res_reg <= (type_reg == rrfi_pkg::REQ_APPLY) ? data_reg : 32'd0;
            ent_reg <= (type_reg == rrfi_pkg::REQ_INSERT) ? 5'(n_reg + 1'b1)
                     : (type_reg == rrfi_pkg::REQ_REMOVE) ? 5'(w_reg) : 5'(n_reg);
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req_ready)
        else $error("item taken while busy");
    a_resp_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) |=> out_v_reg)
        else $error("result lost");
    a_put_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |=> (state_reg == S_RESP))
        else $error("insert write not followed by result");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (n_reg <= CW'(rrfi_pkg::SLOTS)))
        else $error("count out of range");
`endif
endmodule
`default_nettype wire

// ===== verif/register_read_fault_injector_core_tb.sv =====
// Testbench for register_read_fault_injector_core: random and directed requests
// checked against a per-device sorted fault table model. Depends on rrfi_pkg.
`timescale 1ns / 1ps
module register_read_fault_injector_core_tb;

    typedef struct {
        logic [31:0] data;
        logic [1:0]  st;
        logic [4:0]  cnt;
    } rsp_t;

    class fault_scoreboard;
        logic [31:0] f_addr [rrfi_pkg::DEVICES][rrfi_pkg::SLOTS];
        logic [4:0]  f_bit  [rrfi_pkg::DEVICES][rrfi_pkg::SLOTS];
        logic [1:0]  f_mode [rrfi_pkg::DEVICES][rrfi_pkg::SLOTS];
        int          f_cnt  [rrfi_pkg::DEVICES];
        logic [3:0]  present;
        rsp_t        pending[$];
        int          errors;

        function new();
            foreach (f_cnt[d]) f_cnt[d] = 0;
            present = 0;
            errors = 0;
        endfunction

        function void note_request(logic [1:0] rt, logic [1:0] dv, logic [31:0] ad,
                                   logic [4:0] bn, logic [1:0] md, logic [31:0] rd,
                                   logic [2:0] bc);
            rsp_t r;
            int n, pos, w, cnt;
            logic [31:0] fb, off, mask;
            r.data = 32'h0;
            r.st = rrfi_pkg::ST_OK;
            n = f_cnt[dv];
            if (!present[dv]) begin
                r.st = rrfi_pkg::ST_ABSENT;
            end else if (rt == rrfi_pkg::REQ_INSERT) begin
                if (n >= rrfi_pkg::SLOTS) r.st = rrfi_pkg::ST_FULL;
                else begin
                    pos = 0;
                    while (pos < n && ad > f_addr[dv][pos]) pos++;
                    for (int k = n; k > pos; k--) begin
                        f_addr[dv][k] = f_addr[dv][k-1];
                        f_bit[dv][k] = f_bit[dv][k-1];
                        f_mode[dv][k] = f_mode[dv][k-1];
                    end
                    f_addr[dv][pos] = ad;
                    f_bit[dv][pos] = bn;
                    f_mode[dv][pos] = 2'(md % 3);
                    f_cnt[dv] = n + 1;
                end
            end else if (rt == rrfi_pkg::REQ_REMOVE) begin
                w = 0;
                for (int k = 0; k < n; k++)
                    if (!(f_addr[dv][k] == ad && f_bit[dv][k] == bn && f_mode[dv][k] == md))
                    begin
                        f_addr[dv][w] = f_addr[dv][k];
                        f_bit[dv][w] = f_bit[dv][k];
                        f_mode[dv][w] = f_mode[dv][k];
                        w++;
                    end
                f_cnt[dv] = w;
            end else if (rt == rrfi_pkg::REQ_APPLY) begin
                cnt = (bc > 3'd4) ? 4 : int'(bc);
                r.data = rd;
                for (int k = 0; k < n; k++) begin
                    fb = f_addr[dv][k] + 32'(f_bit[dv][k] / 8);
                    off = fb - ad;
                    if (off < 32'(cnt)) begin
                        mask = 32'd1 << ((f_bit[dv][k] % 8) + off * 8);
                        if (f_mode[dv][k] == rrfi_pkg::MODE_CLEAR) r.data &= ~mask;
                        else if (f_mode[dv][k] == rrfi_pkg::MODE_SET) r.data |= mask;
                        else if (f_mode[dv][k] == rrfi_pkg::MODE_FLIP) r.data ^= mask;
                    end
                end
            end
            r.cnt = 5'(f_cnt[dv]);
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] d, logic [1:0] s, logic [4:0] c);
            rsp_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result data=%h status=%0d entries=%0d",
                         $time, d, s, c);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d !== e.data) begin
                $display("%0t: result_data exp %h got %h", $time, e.data, d);
                errors++;
            end
            if (s !== e.st) begin
                $display("%0t: status exp %0d got %0d", $time, e.st, s);
                errors++;
            end
            if (c !== e.cnt) begin
                $display("%0t: entries_now exp %0d got %0d", $time, e.cnt, c);
                errors++;
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        req_valid, req_ready;
    logic [1:0]  req_type, device, fault_mode;
    logic [31:0] address, read_data;
    logic [4:0]  bit_number;
    logic [2:0]  byte_count;
    logic        rsp_valid, rsp_ready;
    logic [31:0] result_data;
    logic [1:0]  status;
    logic [4:0]  entries_now;
    logic        cfg_we;
    logic [3:0]  cfg_data;

    fault_scoreboard sb;
    int send_idle, recv_idle;
    bit recv_hold;
    int quiet;
    logic [31:0] addr_pool [8];

    register_read_fault_injector_core DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .req_type(req_type), .device(device), .address(address),
        .bit_number(bit_number), .fault_mode(fault_mode),
        .read_data(read_data), .byte_count(byte_count),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .result_data(result_data), .status(status), .entries_now(entries_now),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (req_valid && req_ready)
            sb.note_request(req_type, device, address, bit_number, fault_mode,
                            read_data, byte_count);
        if (rsp_valid && rsp_ready)
            sb.check_result(result_data, status, entries_now);
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
        else quiet++;
        if (quiet > 20000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (recv_hold) rsp_ready <= 1'b0;
        else rsp_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_present(input logic [3:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.present = v;
    endtask

    // valid stays up after an accept until the next item or an idle cycle
    task automatic send(input logic [1:0] rt, input logic [1:0] dv, input logic [31:0] ad,
                        input logic [4:0] bn, input logic [1:0] md, input logic [31:0] rd,
                        input logic [2:0] bc);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= rt; device <= dv; address <= ad; bit_number <= bn;
        fault_mode <= md; read_data <= rd; byte_count <= bc;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic send_random();
        int p;
        logic [31:0] ad;
        logic [1:0] rt;
        p = $urandom_range(99);
        rt = (p < 40) ? rrfi_pkg::REQ_INSERT : (p < 60) ? rrfi_pkg::REQ_REMOVE
           : (p < 97) ? rrfi_pkg::REQ_APPLY : rrfi_pkg::REQ_RSVD;
        ad = ($urandom_range(3) == 0) ? $urandom() : addr_pool[3'($urandom_range(7))]
             + $urandom_range(5);
        send(rt, 2'($urandom_range(3)), ad, 5'($urandom_range(31)), 2'($urandom_range(3)),
             $urandom(), 3'($urandom_range(7)));
    endtask

    task automatic random_phase(input int n, input int si, input int ri);
        send_idle = si;
        recv_idle = ri;
        repeat (n) send_random();
    endtask

    initial
    begin
        sb = new();
        rst_n = 0; req_valid = 0; rsp_ready = 0; cfg_we = 0; cfg_data = 0;
        req_type = 0; device = 0; address = 0; bit_number = 0; fault_mode = 0;
        read_data = 0; byte_count = 0;
        send_idle = 0; recv_idle = 0; recv_hold = 0; quiet = 0;
        foreach (addr_pool[i]) addr_pool[i] = $urandom();
        addr_pool[0] = 32'hFFFF_FFFE;
        addr_pool[1] = 32'h0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: absent, then all present
        send(rrfi_pkg::REQ_INSERT, 2'd0, 32'h10, 5'd0, rrfi_pkg::MODE_SET, 32'h0, 3'd1);
        send(rrfi_pkg::REQ_APPLY, 2'd3, 32'h10, 5'd0, rrfi_pkg::MODE_CLEAR,
             32'hFFFF_FFFF, 3'd4);
        drain();
        write_present(4'hF);
        send(rrfi_pkg::REQ_INSERT, 2'd0, 32'hFFFF_FFFF, 5'd31, rrfi_pkg::MODE_SET,
             32'h0, 3'd0);
        send(rrfi_pkg::REQ_INSERT, 2'd0, 32'h0, 5'd0, rrfi_pkg::MODE_CLEAR, 32'h0, 3'd0);
        send(rrfi_pkg::REQ_INSERT, 2'd0, 32'h0, 5'd9, rrfi_pkg::MODE_RSVD, 32'h0, 3'd0);
        send(rrfi_pkg::REQ_INSERT, 2'd0, 32'h0, 5'd17, rrfi_pkg::MODE_FLIP, 32'h0, 3'd0);
        send(rrfi_pkg::REQ_APPLY, 2'd0, 32'h0, 5'd31, rrfi_pkg::MODE_CLEAR, 32'h0, 3'd4);
        send(rrfi_pkg::REQ_APPLY, 2'd0, 32'hFFFF_FFFF, 5'd0, rrfi_pkg::MODE_CLEAR,
             32'h0, 3'd7);
        send(rrfi_pkg::REQ_APPLY, 2'd0, 32'h0, 5'd0, rrfi_pkg::MODE_CLEAR,
             32'hA5A5_5A5A, 3'd0);
        send(rrfi_pkg::REQ_APPLY, 2'd0, 32'h2, 5'd0, rrfi_pkg::MODE_CLEAR, 32'h0, 3'd1);
        send(rrfi_pkg::REQ_RSVD, 2'd0, 32'h0, 5'd0, rrfi_pkg::MODE_CLEAR,
             32'hFFFF_FFFF, 3'd4);
        send(rrfi_pkg::REQ_REMOVE, 2'd0, 32'h0, 5'd9, rrfi_pkg::MODE_RSVD, 32'h0, 3'd0);
        send(rrfi_pkg::REQ_REMOVE, 2'd0, 32'h0, 5'd9, rrfi_pkg::MODE_CLEAR, 32'h0, 3'd0);
        for (int i = 0; i < 17; i++)
            send(rrfi_pkg::REQ_INSERT, 2'd1, 32'h20, 5'd5, rrfi_pkg::MODE_FLIP,
                 32'h0, 3'd0);
        send(rrfi_pkg::REQ_REMOVE, 2'd1, 32'h20, 5'd5, rrfi_pkg::MODE_FLIP, 32'h0, 3'd0);
        drain();
        write_present(4'b0101);
        send(rrfi_pkg::REQ_INSERT, 2'd1, 32'h20, 5'd5, rrfi_pkg::MODE_FLIP, 32'h0, 3'd0);
        drain();
        write_present(4'hF);

        random_phase(300, 0, 0);
        // long receiver hold while sender keeps offering
        fork
            begin
                recv_hold = 1;
                repeat (400) @(posedge clk);
                recv_hold = 0;
            end
            random_phase(30, 0, 0);
        join
        drain();
        random_phase(300, 80, 0);
        random_phase(300, 0, 80);
        drain();
        write_present(4'b1010);
        random_phase(150, 6, 6);
        drain();
        write_present(4'hF);
        random_phase(300, 6, 6);
        send_idle = 0; recv_idle = 0;
        repeat (20) send(rrfi_pkg::REQ_REMOVE, 2'($urandom_range(3)), $urandom(),
                         5'($urandom_range(31)), 2'($urandom_range(3)), $urandom(),
                         3'($urandom_range(7)));
        random_phase(100, 0, 0);
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
